/* hw/rtl/pmhd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackStream marker header decode package
// Shared types, type and status codes, and marker byte constants.
// ----------------------------------------------------------------------------
package pmhd_pkg;

  typedef enum logic [3:0] {
    T_INT    = 4'd0,
    T_NULL   = 4'd1,
    T_FLOAT  = 4'd2,
    T_BOOL   = 4'd3,
    T_BYTES  = 4'd4,
    T_TEXT   = 4'd5,
    T_LIST   = 4'd6,
    T_MAP    = 4'd7,
    T_STRUCT = 4'd8,
    T_END    = 4'd9,
    T_RSVD   = 4'd10
  } value_type_t;

  typedef enum logic [1:0] {
    ST_DECODED   = 2'd0,
    ST_TYPE_ONLY = 2'd1,
    ST_RESERVED  = 2'd2
  } status_t;

  // Header lengths in bytes.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;
  localparam logic [2:0] LEN_5    = 3'd5;

  // Marker bytes and marker ranges.
  localparam logic [7:0] MK_POS_INT_LO  = 8'h00;
  localparam logic [7:0] MK_POS_INT_HI  = 8'h7F;
  localparam logic [7:0] MK_TEXT_T_LO   = 8'h80;
  localparam logic [7:0] MK_TEXT_T_HI   = 8'h8F;
  localparam logic [7:0] MK_LIST_T_LO   = 8'h90;
  localparam logic [7:0] MK_LIST_T_HI   = 8'h9F;
  localparam logic [7:0] MK_MAP_T_LO    = 8'hA0;
  localparam logic [7:0] MK_MAP_T_HI    = 8'hAF;
  localparam logic [7:0] MK_STRUCT_T_LO = 8'hB0;
  localparam logic [7:0] MK_STRUCT_T_HI = 8'hBF;
  localparam logic [7:0] MK_NULL        = 8'hC0;
  localparam logic [7:0] MK_FLOAT       = 8'hC1;
  localparam logic [7:0] MK_FALSE       = 8'hC2;
  localparam logic [7:0] MK_TRUE        = 8'hC3;
  localparam logic [7:0] MK_INT_LO      = 8'hC8;
  localparam logic [7:0] MK_INT_HI      = 8'hCB;
  localparam logic [7:0] MK_BYTES_LO    = 8'hCC;
  localparam logic [7:0] MK_BYTES_HI    = 8'hCE;
  localparam logic [7:0] MK_TEXT_LO     = 8'hD0;
  localparam logic [7:0] MK_TEXT_HI     = 8'hD2;
  localparam logic [7:0] MK_LIST8       = 8'hD4;
  localparam logic [7:0] MK_LIST16      = 8'hD5;
  localparam logic [7:0] MK_LIST32      = 8'hD6;
  localparam logic [7:0] MK_LIST_STREAM = 8'hD7;
  localparam logic [7:0] MK_MAP_LO      = 8'hD8;
  localparam logic [7:0] MK_MAP_HI      = 8'hDB;
  localparam logic [7:0] MK_STRUCT8     = 8'hDC;
  localparam logic [7:0] MK_STRUCT16    = 8'hDD;
  localparam logic [7:0] MK_END         = 8'hDF;
  localparam logic [7:0] MK_NEG_INT_LO  = 8'hF0;
  localparam logic [7:0] MK_NEG_INT_HI  = 8'hFF;

  // Five byte window starting at a value's marker.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
  } window_t;

  typedef struct packed {
    value_type_t       value_type;
    status_t           status;
    logic [2:0]        header_length;
    logic [31:0]       item_count;
    logic              streamed_list;
    logic [7:0]        signature;
    logic signed [7:0] scalar_value;
  } result_t;

endpackage

/* hw/rtl/pmhd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackStream marker decode input stage
// Registers one byte window per transfer and holds it while stalled.
// ----------------------------------------------------------------------------
module pmhd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pmhd_pkg::window_t in_data,
  output logic             q_valid,
  input  logic             q_stall,
  output pmhd_pkg::window_t q_data
);

  logic              valid_r;
  logic              valid_nxt;
  pmhd_pkg::window_t data_r;
  logic              load;

  // The stage can take a new window whenever its content moves on or it is empty.
  assign in_stall  = valid_r && q_stall;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign q_valid = valid_r;
  assign q_data  = data_r;

endmodule

/* hw/rtl/pmhd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackStream marker decode logic
// Classifies the marker byte and extracts the header fields of one window.
// ----------------------------------------------------------------------------
module pmhd_decode (
  input  pmhd_pkg::window_t win,
  output pmhd_pkg::result_t res
);

  always_comb begin
    res               = '0;
    res.value_type    = pmhd_pkg::T_RSVD;
    res.status        = pmhd_pkg::ST_RESERVED;
    res.header_length = pmhd_pkg::LEN_NONE;
    unique case (win.byte0) inside
      [pmhd_pkg::MK_POS_INT_LO:pmhd_pkg::MK_POS_INT_HI],
      [pmhd_pkg::MK_NEG_INT_LO:pmhd_pkg::MK_NEG_INT_HI]: begin
        // The marker byte already is the two's complement value.
        res.value_type    = pmhd_pkg::T_INT;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_1;
        res.scalar_value  = signed'(win.byte0);
      end
      [pmhd_pkg::MK_INT_LO:pmhd_pkg::MK_INT_HI]: begin
        res.value_type = pmhd_pkg::T_INT;
        res.status     = pmhd_pkg::ST_TYPE_ONLY;
      end
      pmhd_pkg::MK_NULL: begin
        res.value_type    = pmhd_pkg::T_NULL;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_1;
      end
      pmhd_pkg::MK_FLOAT: begin
        res.value_type = pmhd_pkg::T_FLOAT;
        res.status     = pmhd_pkg::ST_TYPE_ONLY;
      end
      pmhd_pkg::MK_FALSE, pmhd_pkg::MK_TRUE: begin
        res.value_type    = pmhd_pkg::T_BOOL;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_1;
        res.scalar_value  = {7'd0, win.byte0 == pmhd_pkg::MK_TRUE};
      end
      [pmhd_pkg::MK_BYTES_LO:pmhd_pkg::MK_BYTES_HI]: begin
        res.value_type = pmhd_pkg::T_BYTES;
        res.status     = pmhd_pkg::ST_TYPE_ONLY;
      end
      [pmhd_pkg::MK_TEXT_T_LO:pmhd_pkg::MK_TEXT_T_HI],
      [pmhd_pkg::MK_TEXT_LO:pmhd_pkg::MK_TEXT_HI]: begin
        res.value_type = pmhd_pkg::T_TEXT;
        res.status     = pmhd_pkg::ST_TYPE_ONLY;
      end
      [pmhd_pkg::MK_LIST_T_LO:pmhd_pkg::MK_LIST_T_HI]: begin
        res.value_type    = pmhd_pkg::T_LIST;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_1;
        res.item_count    = {28'd0, win.byte0[3:0]};
      end
      pmhd_pkg::MK_LIST8: begin
        res.value_type    = pmhd_pkg::T_LIST;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_2;
        res.item_count    = {24'd0, win.byte1};
      end
      pmhd_pkg::MK_LIST16: begin
        res.value_type    = pmhd_pkg::T_LIST;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_3;
        res.item_count    = {16'd0, win.byte1, win.byte2};
      end
      pmhd_pkg::MK_LIST32: begin
        res.value_type    = pmhd_pkg::T_LIST;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_5;
        res.item_count    = {win.byte1, win.byte2, win.byte3, win.byte4};
      end
      pmhd_pkg::MK_LIST_STREAM: begin
        res.value_type    = pmhd_pkg::T_LIST;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_1;
        res.streamed_list = 1'b1;
      end
      [pmhd_pkg::MK_MAP_T_LO:pmhd_pkg::MK_MAP_T_HI],
      [pmhd_pkg::MK_MAP_LO:pmhd_pkg::MK_MAP_HI]: begin
        res.value_type = pmhd_pkg::T_MAP;
        res.status     = pmhd_pkg::ST_TYPE_ONLY;
      end
      [pmhd_pkg::MK_STRUCT_T_LO:pmhd_pkg::MK_STRUCT_T_HI]: begin
        res.value_type    = pmhd_pkg::T_STRUCT;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_2;
        res.item_count    = {28'd0, win.byte0[3:0]};
        res.signature     = win.byte1;
      end
      pmhd_pkg::MK_STRUCT8: begin
        res.value_type    = pmhd_pkg::T_STRUCT;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_3;
        res.item_count    = {24'd0, win.byte1};
        res.signature     = win.byte2;
      end
      pmhd_pkg::MK_STRUCT16: begin
        res.value_type    = pmhd_pkg::T_STRUCT;
        res.status        = pmhd_pkg::ST_DECODED;
        res.header_length = pmhd_pkg::LEN_4;
        res.item_count    = {16'd0, win.byte1, win.byte2};
        res.signature     = win.byte3;
      end
      pmhd_pkg::MK_END: begin
        res.value_type = pmhd_pkg::T_END;
        res.status     = pmhd_pkg::ST_TYPE_ONLY;
      end
      default: begin
        res.value_type = pmhd_pkg::T_RSVD;
        res.status     = pmhd_pkg::ST_RESERVED;
      end
    endcase
  end

endmodule

/* hw/rtl/pmhd_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackStream marker decode result register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pmhd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              d_valid,
  output logic              d_stall,
  input  pmhd_pkg::result_t d_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pmhd_pkg::result_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  pmhd_pkg::result_t data_r;
  logic              load;

  assign d_stall   = valid_r && out_stall;
  assign load      = d_valid && !d_stall;
  assign valid_nxt = d_stall ? valid_r : d_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= d_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hw/rtl/packstream_marker_header_decode_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackStream marker header decoder, top level
// Classifies a serialized value's marker byte and decodes its header.
// ----------------------------------------------------------------------------
// Each input transfer carries a five byte window that starts at a value's
// marker byte. The block classifies the marker and, for null, boolean, tiny
// integer, list and structure values, decodes the header and reports how many
// bytes it occupies; other types are classified only, and unassigned markers
// are flagged as reserved. Every input transfer yields exactly one result
// transfer, in order. The path is an input register, one level of decode
// logic and a result register, so a result is presented once its window
// has passed through both registers, and while the output is not stalled the
// block sustains one transfer per cycle. The stall from the result side passes
// back through both registers, so a full pipeline holds two windows while the
// output is stalled, and an emptying register accepts a new window in the
// same cycle it hands its content on.
// The block holds no other state; reset only clears the two valid flags.
// ----------------------------------------------------------------------------
module packstream_marker_header_decode_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte0,
  input  logic [7:0]        in_byte1,
  input  logic [7:0]        in_byte2,
  input  logic [7:0]        in_byte3,
  input  logic [7:0]        in_byte4,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_value_type,
  output logic [1:0]        out_status,
  output logic [2:0]        out_header_length,
  output logic [31:0]       out_item_count,
  output logic              out_streamed_list,
  output logic [7:0]        out_signature,
  output logic signed [7:0] out_scalar_value
);

  pmhd_pkg::window_t in_win;
  pmhd_pkg::window_t q_win;
  logic              q_valid;
  logic              q_stall;
  pmhd_pkg::result_t dec_res;
  pmhd_pkg::result_t out_res;

  assign in_win.byte0 = in_byte0;
  assign in_win.byte1 = in_byte1;
  assign in_win.byte2 = in_byte2;
  assign in_win.byte3 = in_byte3;
  assign in_win.byte4 = in_byte4;

  // Input register: captures the window on each accepted transfer.
  pmhd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_win),
    .q_valid (q_valid),
    .q_stall (q_stall),
    .q_data  (q_win)
  );

  // Marker classification and header field extraction.
  pmhd_decode u_decode (
    .win(q_win),
    .res(dec_res)
  );

  // Result register: holds the decoded result until it is transferred out.
  pmhd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .d_valid  (q_valid),
    .d_stall  (q_stall),
    .d_data   (dec_res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_value_type    = out_res.value_type;
  assign out_status        = out_res.status;
  assign out_header_length = out_res.header_length;
  assign out_item_count    = out_res.item_count;
  assign out_streamed_list = out_res.streamed_list;
  assign out_signature     = out_res.signature;
  assign out_scalar_value  = out_res.scalar_value;

endmodule
